FILE: sv/rswn_pkg.sv
// ----------------------------------------------------------------------------
// rswn_pkg
// Shared constants and codes for the reward synapse weight normalizer.
// ----------------------------------------------------------------------------
package rswn_pkg;

   // Synapse list capacity and the widths that follow from it
   localparam int MAX_SYNAPSES = 64;
   localparam int IDX_W        = $clog2(MAX_SYNAPSES);
   localparam int CNT_W        = $clog2(MAX_SYNAPSES + 1);

   // Fixed datapath widths
   localparam int WEIGHT_W = 32;
   localparam int SUM_W    = 40;                  // plastic weight accumulator
   localparam int PROD_W   = WEIGHT_W + SUM_W;    // |w| * |sum - total|
   localparam int QBITS    = 34;                  // quotient bits kept before clamping
   localparam int DCNT_W   = $clog2(QBITS);

   // e^-1 as an unsigned Q0.32 fraction
   localparam logic [31:0] EINV_Q32 = 32'd1580030169;

   // Store entry: plastic flag over the weight
   localparam int ENTRY_W = WEIGHT_W + 1;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_REWARD_ENABLE = 2'd0,
      CSR_REWARD        = 2'd1,
      CSR_TOTAL_WEIGHT  = 2'd2
   } csr_index_type;

endpackage

FILE: sv/rswn_ram.sv
// ----------------------------------------------------------------------------
// rswn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rswn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: sv/reward_synapse_weight_normalizer.sv
// ----------------------------------------------------------------------------
// reward_synapse_weight_normalizer
// Loads one neuron's synapse list, applies the eligibility-gated reward update,
// sums the plastic weights and on the last beat emits every stored weight.
// ----------------------------------------------------------------------------
// Load: each synapse beat steps through accept, eligibility product, reward
//   product, update and store on one shared 32x32 multiplier; input held off.
// Emit: after the last beat a setup step, then per pass-through weight a read
//   and a result beat, and per normalized weight a read with low product, high
//   product, add, range check, 34 divide steps, saturation and result beat.
// Reset: configuration returns to defaults, sum and count clear; store is not.
module reward_synapse_weight_normalizer (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // weight, eligibility_now, eligibility_max
   input  logic        req_tuser,   // plastic
   input  logic        req_tlast,   // last_synapse
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // new_weight, synapse_index, zero fill
   output logic        rsp_tuser,   // sum_zero
   output logic        rsp_tlast,   // last_result
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IDX_W  = rswn_pkg::IDX_W;
   localparam int CNT_W  = rswn_pkg::CNT_W;
   localparam int SUM_W  = rswn_pkg::SUM_W;
   localparam int PROD_W = rswn_pkg::PROD_W;
   localparam int QBITS  = rswn_pkg::QBITS;
   localparam int DCNT_W = rswn_pkg::DCNT_W;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_ELIG = 12'b000000000010,
      S_RWD  = 12'b000000000100,
      S_UPD  = 12'b000000001000,
      S_PREP = 12'b000000010000,
      S_READ = 12'b000000100000,
      S_MULH = 12'b000001000000,
      S_ACC  = 12'b000010000000,
      S_BIG  = 12'b000100000000,
      S_DIV  = 12'b001000000000,
      S_FIN  = 12'b010000000000,
      S_OUT  = 12'b100000000000
   } state_type;

   // Saturate a 48-bit signed value to 32 bits
   function automatic logic [31:0] sat32(input logic [47:0] x);
      logic [31:0] r;
      if ((x[47:31] == '0) || (x[47:31] == '1)) begin
         r = x[31:0];
      end else if (x[47]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] x);
      return x[31] ? (32'd0 - x) : x;
   endfunction

   function automatic logic [SUM_W-1:0] mag40(input logic [SUM_W-1:0] x);
      return x[SUM_W-1] ? ({SUM_W{1'b0}} - x) : x;
   endfunction

   // Control registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              rwd_en_ff, rwd_en_in;
   logic [31:0]       reward_ff, reward_in;
   logic [31:0]       total_ff, total_in;

   // Payload registers
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [31:0]       w_ff, w_in;
   logic              p_ff, p_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       mx_ff, mx_in;
   logic              last_ff, last_in;
   logic              elig_ff, elig_in;
   logic [63:0]       prod_ff, prod_in;
   logic [31:0]       magw_ff, magw_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0]  mdiff_ff, mdiff_in;
   logic [SUM_W-1:0]  msum_ff, msum_in;
   logic              negsd_ff, negsd_in;
   logic              zero_ff, zero_in;
   logic              big_ff, big_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QBITS-1:0]  low_ff, low_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [31:0]       res_w_ff, res_w_in;
   logic [5:0]        res_idx_ff, res_idx_in;
   logic              res_last_ff, res_last_in;

   // Shared multiplier and datapath helpers
   logic [31:0]       mul_a, mul_b;
   logic [47:0]       rterm, radd, wsum;
   logic [31:0]       w_upd;
   logic              store_ok;
   logic [SUM_W-1:0]  diff;
   logic [SUM_W:0]    dtrial, dsub;
   logic              dge;
   logic [QBITS:0]    qmag;
   logic [QBITS+1:0]  qsgn;
   logic [47:0]       wfin;
   logic              qneg;
   logic [31:0]       rd_w;
   logic              rd_p;
   logic              ram_we;
   logic [rswn_pkg::ENTRY_W-1:0] ram_rdata;
   logic              rsp_done;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {2'b00, res_idx_ff, res_w_ff};
   assign rsp_tuser  = zero_ff;
   assign rsp_tlast  = res_last_ff;
   assign rsp_done   = rsp_tvalid && rsp_tready;

   assign rd_w = ram_rdata[31:0];
   assign rd_p = ram_rdata[rswn_pkg::ENTRY_W-1];

   // Reward update of the loaded weight, truncated toward zero
   assign rterm    = prod_ff[63:16];
   assign radd     = (reward_ff[31] ^ w_ff[31]) ? (48'd0 - rterm) : rterm;
   assign wsum     = {{16{w_ff[31]}}, w_ff} + radd;
   assign w_upd    = (rwd_en_ff && p_ff && elig_ff) ? sat32(wsum) : w_ff;
   assign store_ok = (count_ff < CNT_W'(rswn_pkg::MAX_SYNAPSES));
   assign ram_we   = (state_ff == S_UPD) && store_ok;

   // Difference to the target for this run
   assign diff = sum_ff - {{(SUM_W-32){total_ff[31]}}, total_ff};

   // One restoring divide step
   assign dtrial = {rem_ff, low_ff[QBITS-1]};
   assign dsub   = dtrial - {1'b0, msum_ff};
   assign dge    = (dtrial >= {1'b0, msum_ff});

   // Signed quotient and final saturated weight
   assign qneg = w_ff[31] ^ negsd_ff;
   assign qmag = big_ff ? {1'b1, {QBITS{1'b0}}} : {1'b0, low_ff};
   assign qsgn = qneg ? ({(QBITS+2){1'b0}} - {1'b0, qmag}) : {1'b0, qmag};
   assign wfin = {{16{w_ff[31]}}, w_ff} - {{(48-QBITS-2){qsgn[QBITS+1]}}, qsgn};

   // Select operands of the shared multiplier
   always_comb begin
      unique case (state_ff)
         S_ELIG:  begin mul_a = mx_ff;           mul_b = rswn_pkg::EINV_Q32; end
         S_RWD:   begin mul_a = mag32(reward_ff); mul_b = mag32(w_ff); end
         S_READ:  begin mul_a = mag32(rd_w);      mul_b = mdiff_ff[31:0]; end
         S_MULH:  begin
            mul_a = magw_ff;
            mul_b = {{(64-SUM_W){1'b0}}, mdiff_ff[SUM_W-1:32]};
         end
         default: begin mul_a = mx_ff;           mul_b = mdiff_ff[31:0]; end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      rwd_en_in   = rwd_en_ff;
      reward_in   = reward_ff;
      total_in    = total_ff;
      k_in        = k_ff;
      w_in        = w_ff;
      p_in        = p_ff;
      now_in      = now_ff;
      mx_in       = mx_ff;
      last_in     = last_ff;
      elig_in     = elig_ff;
      prod_in     = 64'(mul_a * mul_b);
      magw_in     = magw_ff;
      acc_in      = acc_ff;
      mdiff_in    = mdiff_ff;
      msum_in     = msum_ff;
      negsd_in    = negsd_ff;
      zero_in     = zero_ff;
      big_in      = big_ff;
      rem_in      = rem_ff;
      low_in      = low_ff;
      dcnt_in     = dcnt_ff;
      res_w_in    = res_w_ff;
      res_idx_in  = res_idx_ff;
      res_last_in = res_last_ff;

      // Take configuration writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rswn_pkg::CSR_REWARD_ENABLE: rwd_en_in = csr_data[0];
            rswn_pkg::CSR_REWARD:        reward_in = csr_data;
            rswn_pkg::CSR_TOTAL_WEIGHT:  total_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         // Capture a synapse beat
         S_IDLE: begin
            if (req_tvalid) begin
               w_in     = req_tdata[31:0];
               now_in   = req_tdata[63:32];
               mx_in    = req_tdata[95:64];
               p_in     = req_tuser;
               last_in  = req_tlast;
               state_in = S_ELIG;
            end
         end
         // Eligibility product is forming
         S_ELIG: state_in = S_RWD;
         // Compare eligibility, reward product is forming
         S_RWD: begin
            elig_in  = ({now_ff, 32'd0} > prod_ff);
            state_in = S_UPD;
         end
         // Store and accumulate, drop beats past the list capacity
         S_UPD: begin
            if (store_ok) begin
               count_in = count_ff + CNT_W'(1);
               if (p_ff) begin
                  sum_in = sum_ff + {{(SUM_W-32){w_upd[31]}}, w_upd};
               end
            end
            state_in = last_ff ? S_PREP : S_IDLE;
         end
         // Set up the run constants and read the first entry
         S_PREP: begin
            zero_in  = (sum_ff == '0);
            mdiff_in = mag40(diff);
            msum_in  = mag40(sum_ff);
            negsd_in = diff[SUM_W-1] ^ sum_ff[SUM_W-1];
            k_in     = '0;
            state_in = S_READ;
         end
         // Entry is read; start the low partial product or pass it through
         S_READ: begin
            w_in        = rd_w;
            p_in        = rd_p;
            magw_in     = mag32(rd_w);
            res_w_in    = rd_w;
            res_idx_in  = 6'(k_ff);
            res_last_in = ((k_ff + CNT_W'(1)) == count_ff);
            state_in    = (rd_p && !zero_ff) ? S_MULH : S_OUT;
         end
         // Hold the low partial product, high one is forming
         S_MULH: begin
            acc_in   = {{(PROD_W-64){1'b0}}, prod_ff};
            state_in = S_ACC;
         end
         // Add the high partial product
         S_ACC: begin
            acc_in   = acc_ff + {prod_ff[SUM_W-1:0], 32'd0};
            state_in = S_BIG;
         end
         // Clamp check on the upper product bits, load the divider
         S_BIG: begin
            big_in   = ({{(SUM_W-(PROD_W-QBITS)){1'b0}}, acc_ff[PROD_W-1:QBITS]} >= msum_ff);
            rem_in   = {{(SUM_W-(PROD_W-QBITS)){1'b0}}, acc_ff[PROD_W-1:QBITS]};
            low_in   = acc_ff[QBITS-1:0];
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         // One quotient bit per cycle
         S_DIV: begin
            rem_in  = dge ? dsub[SUM_W-1:0] : dtrial[SUM_W-1:0];
            low_in  = {low_ff[QBITS-2:0], dge};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(QBITS - 1)) begin
               state_in = S_FIN;
            end
         end
         // Subtract the correction and saturate
         S_FIN: begin
            res_w_in = sat32(wfin);
            state_in = S_OUT;
         end
         // Present the result beat, advance or end the run
         S_OUT: begin
            if (rsp_tready) begin
               if (res_last_ff) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         sum_ff    <= '0;
         rwd_en_ff <= 1'b1;
         reward_ff <= '0;
         total_ff  <= 32'd65536;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         rwd_en_ff <= rwd_en_in;
         reward_ff <= reward_in;
         total_ff  <= total_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      w_ff        <= w_in;
      p_ff        <= p_in;
      now_ff      <= now_in;
      mx_ff       <= mx_in;
      last_ff     <= last_in;
      elig_ff     <= elig_in;
      prod_ff     <= prod_in;
      magw_ff     <= magw_in;
      acc_ff      <= acc_in;
      mdiff_ff    <= mdiff_in;
      msum_ff     <= msum_in;
      negsd_ff    <= negsd_in;
      zero_ff     <= zero_in;
      big_ff      <= big_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      dcnt_ff     <= dcnt_in;
      res_w_ff    <= res_w_in;
      res_idx_ff  <= res_idx_in;
      res_last_ff <= res_last_in;
   end

   // Weight and plastic flag store
   rswn_ram #(
      .WIDTH (rswn_pkg::ENTRY_W),
      .DEPTH (rswn_pkg::MAX_SYNAPSES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({p_ff, w_upd}),
      .rd_addr (k_in[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(rswn_pkg::MAX_SYNAPSES))
      else $error("stored synapse count beyond capacity");

   a_one_side : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input open while a result is pending");

   a_run_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_done && rsp_tlast) |=> (sum_ff == '0 && count_ff == '0))
      else $error("run state not cleared after the last result");

   a_div_steps : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff <= DCNT_W'(QBITS - 1)))
      else $error("divider step count overrun");
`endif

endmodule

FILE: tb/tb_reward_synapse_weight_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reward_synapse_weight_normalizer
// Streams synapse lists into the normalizer under several register settings.
// A local predictor applies the eligibility-gated reward update and the
// normalization, and every emitted weight is checked field by field against
// it. Both stream sides idle in random bursts, with one long result stall.
// ----------------------------------------------------------------------------
module tb_reward_synapse_weight_normalizer;

   localparam int     RUN_LIMIT    = 400000;
   localparam int     DRAIN_CYCLES = 80;
   localparam int     HOLD_CYCLES  = 600;
   localparam longint W_MAX        = 64'sh0000_0000_7FFF_FFFF;
   localparam longint W_MIN        = 64'shFFFF_FFFF_8000_0000;
   localparam logic [63:0]  E_INV_Q32 = 64'd1580030169;   // e^-1 as Q0.32
   localparam logic [127:0] QUO_CLAMP = 128'd1 << 34;

   typedef struct packed {
      logic [31:0] weight;
      logic        plastic;
      logic [31:0] elig_now;
      logic [31:0] elig_peak;
      logic        last;
   } synapse_type;

   typedef struct {
      logic [31:0] weight;
      logic [5:0]  index;
      logic        last;
      logic        zero;
   } norm_result_type;

   logic clock;
   logic reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata  = '0;   // weight, eligibility_now, eligibility_max
   logic          req_tuser  = 1'b0; // plastic
   logic          req_tlast  = 1'b0; // last_synapse
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;         // new_weight, synapse_index, zero fill
   logic          rsp_tuser;         // sum_zero
   logic          rsp_tlast;         // last_result
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   rswn_pkg::csr_index_type csr_index = rswn_pkg::CSR_REWARD_ENABLE;
   logic [31:0]   csr_data   = '0;

   // Predictor state: register copies and the list being loaded
   logic         cfg_reward_on = 1'b1;
   longint       cfg_reward    = 0;
   longint       cfg_total     = 65536;
   logic [31:0]  stored_weight [rswn_pkg::MAX_SYNAPSES];
   logic         stored_plastic [rswn_pkg::MAX_SYNAPSES];
   longint       plastic_total = 0;
   int           stored_count  = 0;

   synapse_type     synapse_backlog[$];
   norm_result_type weights_due[$];
   synapse_type     on_bus;
   norm_result_type got_due;

   int  synapses_queued = 0;
   int  synapses_loaded = 0;
   int  lists_queued    = 0;
   int  weights_checked = 0;
   int  settings_used   = 0;
   int  mismatch_count  = 0;
   int  cycle_count     = 0;
   int  send_gap        = 0;
   int  stall_left      = 0;
   int  hold_left       = 0;
   logic calm           = 1'b0;
   logic hold_armed     = 1'b0;
   logic hold_done      = 1'b0;

   reward_synapse_weight_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint clip32(input longint x);
      if (x > W_MAX) return W_MAX;
      if (x < W_MIN) return W_MIN;
      return x;
   endfunction

   function automatic logic [63:0] abs64(input longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic crosses_threshold(input logic [31:0] now, input logic [31:0] peak);
      return {now, 32'd0} > ({32'd0, peak} * E_INV_Q32);
   endfunction

   function automatic longint apply_reward(input longint w);
      return clip32(w + (cfg_reward * w) / 64'sd65536);
   endfunction

   // w - w*(sum - target)/sum, quotient truncated toward zero, clamped wide
   function automatic longint normalize_weight(input longint w, input longint sum,
                                               input longint diff);
      logic [127:0] num;
      logic [127:0] quo;
      logic         flip;
      longint       q;
      flip = ((w < 0) != (diff < 0)) != (sum < 0);
      num  = {64'd0, abs64(w)} * {64'd0, abs64(diff)};
      quo  = num / {64'd0, abs64(sum)};
      if (quo > QUO_CLAMP) quo = QUO_CLAMP;
      q = flip ? -$signed(quo[63:0]) : $signed(quo[63:0]);
      return clip32(w - q);
   endfunction

   // Store one accepted beat; on the last beat queue the whole list
   task automatic load_synapse(input synapse_type s);
      longint          w;
      longint          diff;
      longint          r;
      logic            empty_sum;
      norm_result_type res;
      w = $signed(s.weight);
      if (cfg_reward_on && s.plastic && crosses_threshold(s.elig_now, s.elig_peak))
         w = apply_reward(w);
      if (stored_count < rswn_pkg::MAX_SYNAPSES) begin
         stored_weight[stored_count]  = w[31:0];
         stored_plastic[stored_count] = s.plastic;
         if (s.plastic) plastic_total += w;
         stored_count++;
      end
      if (s.last) begin
         empty_sum = (plastic_total == 0);
         diff      = plastic_total - cfg_total;
         for (int k = 0; k < stored_count; k++) begin
            r = $signed(stored_weight[k]);
            if (stored_plastic[k] && !empty_sum) r = normalize_weight(r, plastic_total, diff);
            res.weight = r[31:0];
            res.index  = k[5:0];
            res.last   = (k == stored_count - 1);
            res.zero   = empty_sum;
            weights_due.push_back(res);
         end
         plastic_total = 0;
         stored_count  = 0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Input driver: feed beats from the backlog, with random gaps
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            load_synapse(on_bus);
            synapses_loaded++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (synapse_backlog.size() > 0) begin
               on_bus = synapse_backlog.pop_front();
               req_tdata  <= {on_bus.elig_peak, on_bus.elig_now, on_bus.weight};
               req_tuser  <= on_bus.plastic;
               req_tlast  <= on_bus.last;
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result ready: random stalls, plus one long hold once armed
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed && !hold_done && rsp_tvalid) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------
   task automatic log_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         weights_checked++;
         if (weights_due.size() == 0) begin
            log_mismatch($sformatf("unexpected beat, weight %h index %0d",
                                   rsp_tdata[31:0], rsp_tdata[37:32]));
         end else begin
            got_due = weights_due.pop_front();
            if (rsp_tdata[31:0] !== got_due.weight)
               log_mismatch($sformatf("index %0d new_weight %h, want %h", got_due.index,
                                      rsp_tdata[31:0], got_due.weight));
            if (rsp_tdata[37:32] !== got_due.index)
               log_mismatch($sformatf("synapse_index %0d, want %0d",
                                      rsp_tdata[37:32], got_due.index));
            if (rsp_tlast !== got_due.last)
               log_mismatch($sformatf("index %0d last_result %b, want %b", got_due.index,
                                      rsp_tlast, got_due.last));
            if (rsp_tuser !== got_due.zero)
               log_mismatch($sformatf("index %0d sum_zero %b, want %b", got_due.index,
                                      rsp_tuser, got_due.zero));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d weights outstanding",
                  cycle_count, weights_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic csr_put(input rswn_pkg::csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         rswn_pkg::CSR_REWARD_ENABLE: cfg_reward_on = val[0];
         rswn_pkg::CSR_REWARD:        cfg_reward    = $signed(val);
         rswn_pkg::CSR_TOTAL_WEIGHT:  cfg_total     = $signed(val);
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic on, input logic [31:0] gain,
                               input logic [31:0] target);
      csr_put(rswn_pkg::CSR_REWARD_ENABLE, {31'd0, on});
      csr_put(rswn_pkg::CSR_REWARD, gain);
      csr_put(rswn_pkg::CSR_TOTAL_WEIGHT, target);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic push_synapse(input logic [31:0] w, input logic p, input logic [31:0] now,
                               input logic [31:0] peak, input logic last);
      synapse_type s;
      s = '{weight: w, plastic: p, elig_now: now, elig_peak: peak, last: last};
      synapse_backlog.push_back(s);
      synapses_queued++;
      if (last) lists_queued++;
   endtask

   // Largest now that still fails the eligibility test for this peak
   function automatic logic [31:0] elig_edge(input logic [31:0] peak);
      logic [63:0] prod;
      prod = {32'd0, peak} * E_INV_Q32;
      return prod[63:32];
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2, 3, 4: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
         default:
            case ($urandom_range(0, 4))
               0:       return 32'h7FFFFFFF;
               1:       return 32'h80000000;
               2:       return 32'h00000000;
               3:       return 32'hFFFFFFFF;
               default: return 32'h00010000;
            endcase
      endcase
   endfunction

   task automatic queue_random_list(input int n);
      logic [31:0] now;
      logic [31:0] peak;
      logic        all_fixed;
      all_fixed = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
         peak = $urandom;
         case ($urandom_range(0, 4))
            0: now = $urandom;
            1: now = elig_edge(peak);
            2: now = elig_edge(peak) + 32'd1;
            3: begin
               peak = $urandom_range(0, 1);
               now  = $urandom_range(0, 1);
            end
            default: begin
               peak = peak >> $urandom_range(0, 31);
               now  = $urandom;
            end
         endcase
         push_synapse(rand_weight(), !all_fixed && ($urandom_range(0, 9) < 7), now, peak,
                      i == n - 1);
      end
   endtask

   // Queue random lists until the budget of beats is used up exactly
   task automatic queue_random_lists(input int budget);
      int sent;
      int n;
      sent = 0;
      while (sent < budget) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 8);
         if (n > budget - sent) n = budget - sent;
         queue_random_list(n);
         sent += n;
      end
   endtask

   // Wait until every beat is in and every weight is out, then let it idle
   task automatic settle();
      while (synapses_loaded != synapses_queued || weights_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lists: reward of 1.0 doubles eligible plastic weights
      program_regs(1'b1, 32'h00010000, 32'h00010000);
      // saturation both ways, eligibility edges, non-plastic with high trace
      push_synapse(32'h7FFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
      push_synapse(32'h80000000, 1'b1, 32'h00000001, 32'h00000000, 1'b0);
      push_synapse(32'h00030000, 1'b1, 32'h00000000, 32'h00000000, 1'b0);
      push_synapse(32'h00020000, 1'b0, 32'hFFFFFFFF, 32'h00000000, 1'b0);
      push_synapse(32'h00018000, 1'b1, elig_edge(32'h00010000), 32'h00010000, 1'b0);
      push_synapse(32'h00018000, 1'b1, elig_edge(32'h00010000) + 32'd1, 32'h00010000, 1'b0);
      push_synapse(32'h00000000, 1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b1);
      // no plastic synapse at all
      push_synapse(32'h12345678, 1'b0, 32'hFFFFFFFF, 32'h00000000, 1'b0);
      push_synapse(32'hFFFFFFFF, 1'b0, 32'h00000000, 32'hFFFFFFFF, 1'b1);
      // plastic weights that cancel to a zero sum
      push_synapse(32'h00010000, 1'b1, 32'h00000000, 32'h00010000, 1'b0);
      push_synapse(32'hFFFF0000, 1'b1, 32'h00000000, 32'h00010000, 1'b0);
      push_synapse(32'h00000007, 1'b0, 32'h00000000, 32'h00000000, 1'b1);
      // single-synapse list
      push_synapse(32'h00028000, 1'b1, 32'h00004000, 32'h00008000, 1'b1);
      // tiny sum against large weights drives the quotient past its clamp
      push_synapse(32'h40000000, 1'b1, 32'h00000000, 32'h00000000, 1'b0);
      push_synapse(32'hC0000001, 1'b1, 32'h00000000, 32'h00000000, 1'b0);
      push_synapse(32'h00050000, 1'b0, 32'hFFFFFFFF, 32'h00000001, 1'b1);
      settle();

      // Reward off with a huge gain, zero target
      program_regs(1'b0, 32'h7FFFFFFF, 32'h00000000);
      queue_random_lists(25);
      settle();

      // Most negative gain, largest target; full list under a long result hold
      program_regs(1'b1, 32'h80000000, 32'h7FFFFFFF);
      hold_armed = 1'b1;
      queue_random_list(rswn_pkg::MAX_SYNAPSES);
      queue_random_lists(15);
      settle();

      // Largest gain, most negative target; list runs past capacity
      program_regs(1'b1, 32'h7FFFFFFF, 32'h80000000);
      queue_random_list(rswn_pkg::MAX_SYNAPSES + 2);
      settle();

      // Gain of -1.0 zeroes eligible plastic weights
      program_regs(1'b1, 32'hFFFF0000, $urandom);
      queue_random_lists(20);
      settle();

      // Moderate random gain and target, no idling on either side
      calm = 1'b1;
      program_regs(1'b1, $urandom_range(0, 32'h3FFFF) - 32'h20000, $urandom_range(0, 32'h7FFFF));
      queue_random_lists(20);
      settle();

      $display("ran %0d synapse beats in %0d lists under %0d register settings,",
               synapses_loaded, lists_queued, settings_used);
      $display("%0d weights checked; reward off, extreme gains, zero sums, %0d-cycle hold",
               weights_checked, HOLD_CYCLES);
      if (mismatch_count == 0 && weights_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
